/* sv/timed_lease_lowest_free_allocator_assert.svh */
// ----------------------------------------------------------------------------
// timed lease allocator assertion macros
// concurrent checks on the block clock, disabled while aresetn is low
// ----------------------------------------------------------------------------
`ifndef TIMED_LEASE_LOWEST_FREE_ALLOCATOR_ASSERT_SVH
`define TIMED_LEASE_LOWEST_FREE_ALLOCATOR_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define TLLF_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("tllf assertion failed");

// next-cycle implication
`define TLLF_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("tllf assertion failed");

`else

`define TLLF_ASSERT_IMPL(lbl, ante, cons)
`define TLLF_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

/* sv/tllf_pkg.sv */
// ----------------------------------------------------------------------------
// tllf_pkg
// shared types and constants of the timed lease allocator
// ----------------------------------------------------------------------------
package tllf_pkg;

    localparam int unsigned TOTAL_W   = 48;
    localparam int unsigned TIME_W    = 31;
    localparam int unsigned WEIGHT_W  = 30;
    localparam int unsigned RT_W      = 32;
    localparam int unsigned IDX_OUT_W = 4;
    localparam int unsigned CFG_W     = 5;
    localparam int unsigned ADDR_W    = 3;
    localparam int unsigned DATA_W    = 32;

    localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;
    localparam logic             REG_RESOURCES_IN_USE = 1'b0;

    localparam logic CMD_LEASE = 1'b0;
    localparam logic CMD_READ  = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SWEEP,
        ST_ADD,
        ST_RDOUT,
        ST_OUT
    } state_t;

    typedef enum logic {
        ALU_GE,
        ALU_SATADD
    } alu_op_t;

    typedef struct packed {
        logic               flag;
        logic [TOTAL_W-1:0] value;
    } alu_res_t;

    typedef struct packed {
        logic start;
        logic chk;
        logic in_limit;
        logic set;
    } pool_ctrl_t;

endpackage

/* sv/tllf_alu.sv */
// ----------------------------------------------------------------------------
// tllf_alu
// shared 48-bit unit: greater-or-equal compare and saturating add
// ----------------------------------------------------------------------------
module tllf_alu (
    input  tllf_pkg::alu_op_t                op,
    input  logic [tllf_pkg::TOTAL_W-1:0]     opa,
    input  logic [tllf_pkg::TOTAL_W-1:0]     opb,
    output tllf_pkg::alu_res_t               res
);

    logic [tllf_pkg::TOTAL_W:0] addend;
    logic [tllf_pkg::TOTAL_W:0] carry_in;
    logic [tllf_pkg::TOTAL_W:0] sum;

    always_comb begin
        case (op)
            tllf_pkg::ALU_GE: begin
                addend   = ~{1'b0, opb};
                carry_in = {{tllf_pkg::TOTAL_W{1'b0}}, 1'b1};
            end
            default: begin
                addend   = {1'b0, opb};
                carry_in = '0;
            end
        endcase
        sum = {1'b0, opa} + addend + carry_in;
        case (op)
            tllf_pkg::ALU_GE: begin
                res.flag  = ~sum[tllf_pkg::TOTAL_W];
                res.value = sum[tllf_pkg::TOTAL_W-1:0];
            end
            default: begin
                res.flag  = sum[tllf_pkg::TOTAL_W];
                res.value = sum[tllf_pkg::TOTAL_W] ? '1 : sum[tllf_pkg::TOTAL_W-1:0];
            end
        endcase
    end

endmodule

/* sv/tllf_pool.sv */
// ----------------------------------------------------------------------------
// tllf_pool
// busy mask with release on expiry and lowest free tracking during the sweep
// ----------------------------------------------------------------------------
module tllf_pool #(
    parameter int unsigned NUM_RESOURCES = 16,
    parameter int unsigned IDX_W         = 4
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  tllf_pkg::pool_ctrl_t    ctrl,
    input  logic [IDX_W-1:0]        chk_idx,
    input  logic                    ret_due,
    input  logic [IDX_W-1:0]        set_idx,
    output logic                    found,
    output logic [IDX_W-1:0]        grant_idx
);

    logic [NUM_RESOURCES-1:0] busy_reg, busy_next;
    logic                     found_reg, found_next;
    logic [IDX_W-1:0]         grant_reg, grant_next;
    logic                     chk_busy;
    logic                     chk_free;

    always_comb begin
        chk_busy   = busy_reg[chk_idx];
        chk_free   = ~chk_busy | ret_due;
        busy_next  = busy_reg;
        found_next = found_reg;
        grant_next = grant_reg;
        if (ctrl.chk && chk_busy && ret_due) begin
            busy_next[chk_idx] = 1'b0;
        end
        if (ctrl.set) begin
            busy_next[set_idx] = 1'b1;
        end
        if (ctrl.start) begin
            found_next = 1'b0;
        end else if (ctrl.chk && chk_free && ctrl.in_limit && !found_reg) begin
            found_next = 1'b1;
            grant_next = chk_idx;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= '0;
            found_reg <= 1'b0;
        end else begin
            busy_reg  <= busy_next;
            found_reg <= found_next;
        end
    end

    always_ff @(posedge aclk) begin
        grant_reg <= grant_next;
    end

    assign found     = found_reg;
    assign grant_idx = grant_reg;

endmodule

/* sv/timed_lease_lowest_free_allocator.sv */
// A lease request holds s_ready low from acceptance until its result word is loaded. The
// return-time memory is swept one entry per cycle through the shared compare unit, releasing
// expired leases and noting the lowest free resource, and the read pipeline is then drained.
// The grant then writes the new return time and the saturated total through the same unit. A
// read of a total fetches the entry on acceptance and registers it in ST_RDOUT. Both wait
// longer while the previous result word still sits unaccepted in the output register. After
// reset a clearing pass zeroes the totals memory before the first word is accepted;
// configuration writes are taken throughout.
// ----------------------------------------------------------------------------
// timed_lease_lowest_free_allocator
// lowest-index free resource allocator with timed leases and weight totals
// ----------------------------------------------------------------------------
`include "timed_lease_lowest_free_allocator_assert.svh"

module timed_lease_lowest_free_allocator #(
    parameter int unsigned NUM_RESOURCES = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [tllf_pkg::ADDR_W-1:0]         paddr,
    input  logic [tllf_pkg::DATA_W-1:0]         pwdata,
    output logic [tllf_pkg::DATA_W-1:0]         prdata,
    output logic                                pready,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_cmd,
    input  logic [tllf_pkg::TIME_W-1:0]         s_req_time,
    input  logic [tllf_pkg::WEIGHT_W-1:0]       s_weight,
    input  logic [tllf_pkg::TIME_W-1:0]         s_hold_time,
    input  logic [tllf_pkg::IDX_OUT_W-1:0]      s_read_index,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_granted,
    output logic [tllf_pkg::IDX_OUT_W-1:0]      m_res_index,
    output logic [tllf_pkg::TOTAL_W-1:0]        m_total
);

    localparam int unsigned IDX_W = (NUM_RESOURCES > 1) ? $clog2(NUM_RESOURCES) : 1;
    localparam int unsigned CNT_W = $clog2(NUM_RESOURCES + 1);
    localparam int unsigned CMP_W = (IDX_W > tllf_pkg::CFG_W) ? IDX_W : tllf_pkg::CFG_W;

    tllf_pkg::state_t state_reg, state_next;

    logic [CNT_W-1:0]                    cnt_reg, cnt_next;
    logic                                pend_vld_reg, pend_vld_next;
    logic [IDX_W-1:0]                    pend_idx_reg, pend_idx_next;
    logic [tllf_pkg::CFG_W-1:0]          cfg_reg;
    logic [tllf_pkg::TIME_W-1:0]         now_reg;
    logic [tllf_pkg::WEIGHT_W-1:0]       weight_reg;
    logic [tllf_pkg::TIME_W-1:0]         hold_reg;
    logic [tllf_pkg::IDX_OUT_W-1:0]      rd_reg;
    logic                                rd_ok_reg;
    logic                                res_granted_reg, res_granted_next;
    logic [tllf_pkg::IDX_OUT_W-1:0]      res_index_reg, res_index_next;
    logic [tllf_pkg::TOTAL_W-1:0]        res_total_reg, res_total_next;
    logic                                m_valid_reg, m_valid_next;
    logic                                m_granted_reg;
    logic [tllf_pkg::IDX_OUT_W-1:0]      m_res_index_reg;
    logic [tllf_pkg::TOTAL_W-1:0]        m_total_reg;

    logic [tllf_pkg::RT_W-1:0]           rt_mem [NUM_RESOURCES];
    logic [tllf_pkg::RT_W-1:0]           rt_q_reg;
    logic                                rt_we, rt_re;
    logic [IDX_W-1:0]                    rt_raddr;
    logic [tllf_pkg::TOTAL_W-1:0]        tot_mem [NUM_RESOURCES];
    logic [tllf_pkg::TOTAL_W-1:0]        tot_q_reg;
    logic                                tot_we, tot_re;
    logic [IDX_W-1:0]                    tot_waddr, tot_raddr;
    logic [tllf_pkg::TOTAL_W-1:0]        tot_wdata;

    logic                                s_accept;
    logic                                m_load;
    logic                                cfg_write;
    logic                                rd_ok;

    tllf_pkg::alu_op_t                   alu_op;
    logic [tllf_pkg::TOTAL_W-1:0]        alu_opa, alu_opb;
    tllf_pkg::alu_res_t                  alu_res;

    tllf_pkg::pool_ctrl_t                pool_ctrl;
    logic                                pool_found;
    logic [IDX_W-1:0]                    pool_grant;

    tllf_alu u_alu (
        .op  (alu_op),
        .opa (alu_opa),
        .opb (alu_opb),
        .res (alu_res)
    );

    tllf_pool #(
        .NUM_RESOURCES (NUM_RESOURCES),
        .IDX_W         (IDX_W)
    ) u_pool (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (pool_ctrl),
        .chk_idx   (pend_idx_reg),
        .ret_due   (alu_res.flag),
        .set_idx   (pool_grant),
        .found     (pool_found),
        .grant_idx (pool_grant)
    );

    // config port
    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite & pready;
    assign prdata    = (paddr[2] == tllf_pkg::REG_RESOURCES_IN_USE)
                       ? {{(tllf_pkg::DATA_W - tllf_pkg::CFG_W){1'b0}}, cfg_reg} : '0;

    assign s_ready  = (state_reg == tllf_pkg::ST_IDLE);
    assign s_accept = s_valid & s_ready;
    assign rd_ok    = ({{(32 - tllf_pkg::IDX_OUT_W){1'b0}}, s_read_index}
                       < 32'(NUM_RESOURCES));

    always_comb begin
        state_next       = state_reg;
        cnt_next         = cnt_reg;
        pend_vld_next    = 1'b0;
        pend_idx_next    = pend_idx_reg;
        res_granted_next = res_granted_reg;
        res_index_next   = res_index_reg;
        res_total_next   = res_total_reg;
        m_load           = 1'b0;
        rt_we            = 1'b0;
        rt_re            = 1'b0;
        rt_raddr         = cnt_reg[IDX_W-1:0];
        tot_we           = 1'b0;
        tot_re           = 1'b0;
        tot_waddr        = pool_grant;
        tot_raddr        = pool_grant;
        tot_wdata        = alu_res.value;
        alu_op           = tllf_pkg::ALU_GE;
        alu_opa          = {{(tllf_pkg::TOTAL_W - tllf_pkg::TIME_W){1'b0}}, now_reg};
        alu_opb          = {{(tllf_pkg::TOTAL_W - tllf_pkg::RT_W){1'b0}}, rt_q_reg};
        pool_ctrl        = '0;
        pool_ctrl.in_limit = (CMP_W'(pend_idx_reg) < CMP_W'(cfg_reg));

        case (state_reg)
            tllf_pkg::ST_CLEAR: begin
                tot_we    = 1'b1;
                tot_waddr = cnt_reg[IDX_W-1:0];
                tot_wdata = '0;
                if (cnt_reg == CNT_W'(NUM_RESOURCES - 1)) begin
                    cnt_next   = '0;
                    state_next = tllf_pkg::ST_IDLE;
                end else begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            tllf_pkg::ST_IDLE: begin
                if (s_accept) begin
                    if (s_cmd == tllf_pkg::CMD_READ) begin
                        tot_re     = rd_ok;
                        tot_raddr  = IDX_W'(s_read_index);
                        state_next = tllf_pkg::ST_RDOUT;
                    end else begin
                        pool_ctrl.start = 1'b1;
                        cnt_next        = '0;
                        state_next      = tllf_pkg::ST_SWEEP;
                    end
                end
            end
            tllf_pkg::ST_SWEEP: begin
                pool_ctrl.chk = pend_vld_reg;
                if (cnt_reg != CNT_W'(NUM_RESOURCES)) begin
                    rt_re         = 1'b1;
                    pend_vld_next = 1'b1;
                    pend_idx_next = cnt_reg[IDX_W-1:0];
                    cnt_next      = cnt_reg + CNT_W'(1);
                end else if (!pend_vld_reg) begin
                    if (pool_found) begin
                        // return time through the shared unit
                        alu_op        = tllf_pkg::ALU_SATADD;
                        alu_opb       = {{(tllf_pkg::TOTAL_W - tllf_pkg::TIME_W){1'b0}},
                                         hold_reg};
                        rt_we         = 1'b1;
                        pool_ctrl.set = 1'b1;
                        tot_re        = 1'b1;
                        state_next    = tllf_pkg::ST_ADD;
                    end else begin
                        res_granted_next = 1'b0;
                        res_index_next   = '0;
                        res_total_next   = '0;
                        state_next       = tllf_pkg::ST_OUT;
                    end
                end
            end
            tllf_pkg::ST_ADD: begin
                alu_op           = tllf_pkg::ALU_SATADD;
                alu_opa          = tot_q_reg;
                alu_opb          = {{(tllf_pkg::TOTAL_W - tllf_pkg::WEIGHT_W){1'b0}},
                                    weight_reg};
                tot_we           = 1'b1;
                res_granted_next = 1'b1;
                res_index_next   = tllf_pkg::IDX_OUT_W'(pool_grant);
                res_total_next   = alu_res.value;
                state_next       = tllf_pkg::ST_OUT;
            end
            tllf_pkg::ST_RDOUT: begin
                res_granted_next = rd_ok_reg;
                res_index_next   = rd_reg;
                res_total_next   = rd_ok_reg ? tot_q_reg : '0;
                state_next       = tllf_pkg::ST_OUT;
            end
            tllf_pkg::ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_load     = 1'b1;
                    state_next = tllf_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = tllf_pkg::ST_IDLE;
            end
        endcase

        m_valid_next = m_load | (m_valid_reg & ~m_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= tllf_pkg::ST_CLEAR;
            cnt_reg      <= '0;
            pend_vld_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            cfg_reg      <= tllf_pkg::CFG_RESET;
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            pend_vld_reg <= pend_vld_next;
            m_valid_reg  <= m_valid_next;
            if (cfg_write && paddr[2] == tllf_pkg::REG_RESOURCES_IN_USE) begin
                cfg_reg <= pwdata[tllf_pkg::CFG_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        pend_idx_reg    <= pend_idx_next;
        res_granted_reg <= res_granted_next;
        res_index_reg   <= res_index_next;
        res_total_reg   <= res_total_next;
        if (s_accept) begin
            now_reg    <= s_req_time;
            weight_reg <= s_weight;
            hold_reg   <= s_hold_time;
            rd_reg     <= s_read_index;
            rd_ok_reg  <= rd_ok;
        end
        if (m_load) begin
            m_granted_reg   <= res_granted_reg;
            m_res_index_reg <= res_index_reg;
            m_total_reg     <= res_total_reg;
        end
    end

    // return-time memory
    always_ff @(posedge aclk) begin
        if (rt_we) begin
            rt_mem[pool_grant] <= alu_res.value[tllf_pkg::RT_W-1:0];
        end
        if (rt_re) begin
            rt_q_reg <= rt_mem[rt_raddr];
        end
    end

    // totals memory
    always_ff @(posedge aclk) begin
        if (tot_we) begin
            tot_mem[tot_waddr] <= tot_wdata;
        end
        if (tot_re) begin
            tot_q_reg <= tot_mem[tot_raddr];
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_granted   = m_granted_reg;
    assign m_res_index = m_res_index_reg;
    assign m_total     = m_total_reg;

    `TLLF_ASSERT_NEXT(a_busy_after_accept, s_accept, !s_ready)
    `TLLF_ASSERT_IMPL(a_valid_from_out, $rose(m_valid_reg), $past(state_reg == tllf_pkg::ST_OUT))
    `TLLF_ASSERT_IMPL(a_cnt_bound, 1'b1, cnt_reg <= CNT_W'(NUM_RESOURCES))
    `TLLF_ASSERT_IMPL(a_no_accept_clear, state_reg == tllf_pkg::ST_CLEAR, !s_ready)

endmodule

/* test/lease_grant_checker.sv */
// ----------------------------------------------------------------------------
// lease_grant_checker
// watches the register, request and result ports of the lease allocator,
// keeps its own copy of the lease pool and the weight totals, works out the
// result word of every accepted request and compares it field by field with
// what the block returns, oldest first
// ----------------------------------------------------------------------------
module lease_grant_checker #(
    parameter int unsigned POOL_SIZE = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic                                pready,
    input  logic [tllf_pkg::ADDR_W-1:0]         paddr,
    input  logic [tllf_pkg::DATA_W-1:0]         pwdata,
    input  logic                                s_valid,
    input  logic                                s_ready,
    input  logic                                s_cmd,
    input  logic [tllf_pkg::TIME_W-1:0]         s_req_time,
    input  logic [tllf_pkg::WEIGHT_W-1:0]       s_weight,
    input  logic [tllf_pkg::TIME_W-1:0]         s_hold_time,
    input  logic [tllf_pkg::IDX_OUT_W-1:0]      s_read_index,
    input  logic                                m_valid,
    input  logic                                m_ready,
    input  logic                                m_granted,
    input  logic [tllf_pkg::IDX_OUT_W-1:0]      m_res_index,
    input  logic [tllf_pkg::TOTAL_W-1:0]        m_total,
    output int unsigned                         grants_awaited,
    output int unsigned                         mismatch_count
);

    import tllf_pkg::*;

    typedef struct packed {
        logic                 granted;
        logic [IDX_OUT_W-1:0] res_index;
        logic [TOTAL_W-1:0]   total;
    } grant_word_t;

    grant_word_t        awaited_q[$];
    logic [CFG_W-1:0]   pool_limit;
    logic               leased    [POOL_SIZE];
    logic [RT_W-1:0]    lease_end [POOL_SIZE];
    logic [TOTAL_W-1:0] credit    [POOL_SIZE];

    function automatic grant_word_t grant_for(
        input logic                 cmd,
        input logic [TIME_W-1:0]    now,
        input logic [WEIGHT_W-1:0]  w,
        input logic [TIME_W-1:0]    hold,
        input logic [IDX_OUT_W-1:0] idx
    );
        grant_word_t    g;
        int unsigned    lim;
        int unsigned    i;
        logic [TOTAL_W:0] sum;
        g = '0;
        if (cmd == CMD_READ) begin
            g.res_index = idx;
            if (idx < POOL_SIZE) begin
                g.granted = 1'b1;
                g.total   = credit[idx];
            end
            return g;
        end
        // expired leases go back first, so a return wins a tie
        for (i = 0; i < POOL_SIZE; i++) begin
            if (leased[i] && lease_end[i] <= RT_W'(now))
                leased[i] = 1'b0;
        end
        lim = (pool_limit > POOL_SIZE) ? POOL_SIZE : pool_limit;
        for (i = 0; i < lim; i++) begin
            if (!leased[i]) begin
                leased[i]    = 1'b1;
                lease_end[i] = RT_W'(now) + RT_W'(hold);
                sum          = {1'b0, credit[i]} + (TOTAL_W+1)'(w);
                credit[i]    = sum[TOTAL_W] ? {TOTAL_W{1'b1}} : sum[TOTAL_W-1:0];
                g.granted    = 1'b1;
                g.res_index  = i[IDX_OUT_W-1:0];
                g.total      = credit[i];
                return g;
            end
        end
        return g;
    endfunction

    always @(posedge aclk) begin
        grant_word_t want;
        int unsigned i;
        if (!aresetn) begin
            pool_limit = CFG_RESET;
            for (i = 0; i < POOL_SIZE; i++) begin
                leased[i]    = 1'b0;
                lease_end[i] = '0;
                credit[i]    = '0;
            end
            awaited_q.delete();
        end else begin
            if (psel && penable && pwrite && pready
                    && paddr[ADDR_W-1:2] == REG_RESOURCES_IN_USE)
                pool_limit = pwdata[CFG_W-1:0];
            if (m_valid && m_ready) begin
                if (awaited_q.size() == 0) begin
                    $display("%0t: result word with none awaited: granted %0b index %0d total %0d",
                             $time, m_granted, m_res_index, m_total);
                    mismatch_count++;
                end else begin
                    want = awaited_q.pop_front();
                    if (m_granted !== want.granted) begin
                        $display("%0t: granted expected %0b, got %0b",
                                 $time, want.granted, m_granted);
                        mismatch_count++;
                    end
                    if (m_res_index !== want.res_index) begin
                        $display("%0t: res_index expected %0d, got %0d",
                                 $time, want.res_index, m_res_index);
                        mismatch_count++;
                    end
                    if (m_total !== want.total) begin
                        $display("%0t: total expected %0d, got %0d",
                                 $time, want.total, m_total);
                        mismatch_count++;
                    end
                end
            end
            if (s_valid && s_ready)
                awaited_q.push_back(grant_for(s_cmd, s_req_time, s_weight,
                                              s_hold_time, s_read_index));
        end
        grants_awaited = awaited_q.size();
    end

endmodule

/* test/timed_lease_lowest_free_allocator_test.sv */
// ----------------------------------------------------------------------------
// timed_lease_lowest_free_allocator_test
// drives lease requests and total reads into the allocator with random gaps
// and result back-pressure, moves the pool size through several settings
// between phases, and reports the verdict from the checker's mismatch count
// ----------------------------------------------------------------------------
module timed_lease_lowest_free_allocator_test;

    import tllf_pkg::*;

    localparam int unsigned POOL_SIZE       = 16;
    localparam int unsigned HOLD_OFF_CYCLES = 400;
    localparam int unsigned SETTLE_CYCLES   = 60;
    localparam int unsigned PHASES          = 8;

    localparam logic [ADDR_W-1:0]   ADDR_RESOURCES_IN_USE = {REG_RESOURCES_IN_USE, 2'b00};
    localparam logic [ADDR_W-1:0]   ADDR_SPARE            = {~REG_RESOURCES_IN_USE, 2'b00};
    localparam logic [TIME_W-1:0]   TIME_MAX              = '1;
    localparam logic [WEIGHT_W-1:0] WEIGHT_MAX            = '1;

    logic                   aclk         = 1'b0;
    logic                   aresetn      = 1'b0;
    logic                   psel         = 1'b0;
    logic                   penable      = 1'b0;
    logic                   pwrite       = 1'b0;
    logic [ADDR_W-1:0]      paddr        = '0;
    logic [DATA_W-1:0]      pwdata       = '0;
    logic [DATA_W-1:0]      prdata;
    logic                   pready;
    logic                   s_valid      = 1'b0;
    logic                   s_ready;
    logic                   s_cmd        = CMD_LEASE;
    logic [TIME_W-1:0]      s_req_time   = '0;
    logic [WEIGHT_W-1:0]    s_weight     = '0;
    logic [TIME_W-1:0]      s_hold_time  = '0;
    logic [IDX_OUT_W-1:0]   s_read_index = '0;
    logic                   m_valid;
    logic                   m_ready      = 1'b0;
    logic                   m_granted;
    logic [IDX_OUT_W-1:0]   m_res_index;
    logic [TOTAL_W-1:0]     m_total;

    int unsigned            grants_awaited;
    int unsigned            mismatch_count;
    int unsigned            tx_gap_max   = 3;
    int unsigned            rx_gap_max   = 3;
    logic                   rx_hold_off  = 1'b0;
    logic [TIME_W-1:0]      lease_clock  = '0;

    int unsigned            gap_by_phase   [3]      = '{0, 3, 15};
    logic [CFG_W-1:0]       limit_by_phase [PHASES] = '{16, 1, 31, 9, 16, 2, 0, 16};

    timed_lease_lowest_free_allocator #(
        .NUM_RESOURCES (POOL_SIZE)
    ) dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_cmd        (s_cmd),
        .s_req_time   (s_req_time),
        .s_weight     (s_weight),
        .s_hold_time  (s_hold_time),
        .s_read_index (s_read_index),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_granted    (m_granted),
        .m_res_index  (m_res_index),
        .m_total      (m_total)
    );

    lease_grant_checker #(
        .POOL_SIZE (POOL_SIZE)
    ) grant_check (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .pready         (pready),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_cmd          (s_cmd),
        .s_req_time     (s_req_time),
        .s_weight       (s_weight),
        .s_hold_time    (s_hold_time),
        .s_read_index   (s_read_index),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_granted      (m_granted),
        .m_res_index    (m_res_index),
        .m_total        (m_total),
        .grants_awaited (grants_awaited),
        .mismatch_count (mismatch_count)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    initial begin
        #5_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // result side: a fresh random stall, possibly none, after every word taken, one long hold-off on request
    initial begin : result_sink
        int unsigned stall_left;
        stall_left = $urandom_range(0, 15);
        forever begin
            @(posedge aclk);
            if (m_ready && m_valid) begin
                if (rx_hold_off) begin
                    stall_left  = HOLD_OFF_CYCLES;
                    rx_hold_off = 1'b0;
                end else begin
                    stall_left = $urandom_range(0, rx_gap_max);
                end
                if (stall_left != 0)
                    m_ready <= 1'b0;
            end else if (!m_ready) begin
                if (stall_left <= 1)
                    m_ready <= 1'b1;
                else
                    stall_left--;
            end
        end
    end

    task automatic offer_word(
        input logic                 cmd,
        input logic [TIME_W-1:0]    t,
        input logic [WEIGHT_W-1:0]  w,
        input logic [TIME_W-1:0]    h,
        input logic [IDX_OUT_W-1:0] idx
    );
        int unsigned gap;
        gap = $urandom_range(0, tx_gap_max);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_cmd        <= cmd;
        s_req_time   <= t;
        s_weight     <= w;
        s_hold_time  <= h;
        s_read_index <= idx;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic request_lease(
        input logic [TIME_W-1:0]   t,
        input logic [WEIGHT_W-1:0] w,
        input logic [TIME_W-1:0]   h
    );
        offer_word(CMD_LEASE, t, w, h, IDX_OUT_W'($urandom()));
    endtask

    task automatic request_total(input logic [IDX_OUT_W-1:0] idx);
        offer_word(CMD_READ, TIME_W'($urandom()), WEIGHT_W'($urandom()),
                   TIME_W'($urandom()), idx);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(negedge aclk); while (grants_awaited != 0);
        @(posedge aclk);
    endtask

    task automatic write_reg(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    // upper data bits are junk, only the low field counts
    task automatic set_pool_limit(input logic [CFG_W-1:0] limit);
        logic [DATA_W-1:0] data;
        data            = $urandom();
        data[CFG_W-1:0] = limit;
        wait_drained();
        write_reg(ADDR_RESOURCES_IN_USE, data);
    endtask

    task automatic random_word();
        int unsigned         pick;
        logic [TIME_W-1:0]   hold;
        logic [WEIGHT_W-1:0] w;
        pick = $urandom_range(0, 99);
        if (pick < 20) begin
            request_total(IDX_OUT_W'($urandom_range(0, POOL_SIZE - 1)));
        end else begin
            pick = $urandom_range(0, 99);
            if (pick < 2)
                lease_clock = TIME_W'($urandom());
            else if (pick < 6)
                lease_clock = lease_clock + TIME_W'($urandom_range(0, 1 << 20));
            else
                lease_clock = lease_clock + TIME_W'($urandom_range(0, 12));
            hold = ($urandom_range(0, 99) < 2) ? TIME_W'($urandom())
                                               : TIME_W'($urandom_range(0, 80));
            w    = ($urandom_range(0, 3) == 0) ? WEIGHT_W'($urandom_range(0, 15))
                                               : WEIGHT_W'($urandom());
            request_lease(lease_clock, w, hold);
        end
    endtask

    initial begin
        int unsigned      phase;
        int unsigned      n;
        int unsigned      words;
        logic [CFG_W-1:0] limit;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        request_total(0);
        request_total(IDX_OUT_W'(POOL_SIZE - 1));
        request_lease(0, WEIGHT_MAX, 0);
        request_lease(0, 1, 10);
        request_lease(2, 0, 5);
        request_lease(7, 3, 1);
        request_lease(7, 9, 4);
        // time going backwards
        request_lease(5, 2, 0);
        request_total(0);

        set_pool_limit(2);
        write_reg(ADDR_SPARE, $urandom());
        request_lease(20, WEIGHT_W'($urandom()), 40);
        request_lease(20, WEIGHT_W'($urandom()), 40);
        request_lease(20, WEIGHT_W'($urandom()), 40);
        request_total(1);

        set_pool_limit(0);
        request_lease(100, WEIGHT_W'($urandom()), 10);

        // above the pool size, treated as the whole pool
        set_pool_limit(31);
        request_lease(100, WEIGHT_W'($urandom()), 30);
        request_lease(100, WEIGHT_W'($urandom()), 30);

        // lowered with resource 1 still out on lease
        set_pool_limit(1);
        request_lease(110, WEIGHT_W'($urandom()), 5);
        request_lease(140, WEIGHT_W'($urandom()), 5);
        request_total(1);

        lease_clock = 200;
        for (phase = 0; phase < PHASES; phase++) begin
            limit = (phase == 3) ? CFG_W'($urandom_range(2, 15)) : limit_by_phase[phase];
            set_pool_limit(limit);
            tx_gap_max = gap_by_phase[phase % 3];
            rx_gap_max = gap_by_phase[(phase + 1) % 3];
            if (phase == 2)
                rx_hold_off = 1'b1;
            words = (limit == 0) ? 40 : 137;
            for (n = 0; n < words; n++)
                random_word();
        end

        // extremes of time and hold, then every total
        set_pool_limit(16);
        tx_gap_max = 3;
        rx_gap_max = 3;
        request_lease(0, WEIGHT_MAX, TIME_MAX);
        request_lease(TIME_MAX, WEIGHT_MAX, 0);
        request_lease(TIME_MAX, 1, TIME_MAX);
        for (n = 0; n < POOL_SIZE; n++)
            request_total(IDX_OUT_W'(n));

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

/* timed_lease_lowest_free_allocator.f */
+incdir+sv
sv/tllf_pkg.sv
sv/tllf_alu.sv
sv/tllf_pool.sv
sv/timed_lease_lowest_free_allocator.sv
test/lease_grant_checker.sv
test/timed_lease_lowest_free_allocator_test.sv
